// ===== hdl/qte_pkg.sv =====
// Shared types, constants and step functions for the quaternion to z-x-y Euler converter.
// Used by the front end, the queue, the square root unit, the CORDIC unit and the back end.
package qte_pkg;

    // Field and datapath types
    typedef logic signed [15:0] quat_t;
    typedef logic signed [31:0] prod_t;
    typedef logic signed [33:0] wide_t;   // Q28 sines and cosines
    typedef logic [56:0] rad_t;           // 2^56 - sp^2
    typedef logic [28:0] root_t;
    typedef logic signed [17:0] angle_t;  // 1/128 degree, before saturation
    typedef logic signed [43:0] cx_t;     // CORDIC vector component
    typedef logic signed [26:0] acc_t;    // angle in 2^-16 degree
    typedef logic [40:0] mag_t;

    localparam int CORDIC_STEPS = 20;
    localparam int NORM_STAGES  = 6;
    localparam int CORDIC_LAT   = 3 + NORM_STAGES + CORDIC_STEPS;
    localparam int SQRT_LAT     = 29;
    localparam int TOTAL_LAT    = SQRT_LAT + CORDIC_LAT;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;
    localparam int MAG_W        = 41;

    localparam wide_t  ONE_Q28     = 34'sd268435456;
    localparam rad_t   RAD_ONE     = 57'h100000000000000;
    localparam acc_t   DEG180_FINE = 27'sd11796480;
    localparam acc_t   ACC_HALF    = 27'sd256;
    localparam angle_t DEG180_OUT  = 18'sd23040;
    localparam angle_t DEG90_OUT   = 18'sd11520;

    localparam int NORM_SH [NORM_STAGES] = '{32, 16, 8, 4, 2, 1};

    // atan(2^-i) in 2^-16 degree
    localparam acc_t ATAN_TAB [CORDIC_STEPS] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379,
        27'sd117304,  27'sd58666,   27'sd29335,  27'sd14668,  27'sd7334,
        27'sd3667,    27'sd1833,    27'sd917,    27'sd458,    27'sd229,
        27'sd115,     27'sd57,      27'sd29,     27'sd14,     27'sd7
    };

    // Item passed from the front end to the back end
    typedef struct packed {
        wide_t sr;
        wide_t cr;
        wide_t sy;
        wide_t cy;
        wide_t sp;
        logic  clamp;
        rad_t  rad;
    } mid_t;

    // CORDIC stage contents
    typedef struct packed {
        logic zero;
        acc_t acc;
        mag_t m;
        cx_t  x;
        cx_t  y;
    } cst_t;

    // Square root stage contents
    typedef struct packed {
        logic [57:0] rad;
        logic [30:0] rem;
        root_t       root;
    } sq_t;

    // One normalize step: shift left by k while the magnitude stays below 2^41
    function automatic cst_t norm_step(cst_t s, int k);
        cst_t r;
        r = s;
        if ((s.m >> (MAG_W - k)) == '0)
        begin
            r.m = s.m << k;
            r.x = s.x <<< k;
            r.y = s.y <<< k;
        end
        return r;
    endfunction

    // One vectoring rotation, step i
    function automatic cst_t cordic_step(cst_t s, int i);
        cst_t r;
        cx_t  xs;
        cx_t  ys;
        r  = s;
        xs = s.x >>> i;
        ys = s.y >>> i;
        if (!s.y[43])
        begin
            r.x   = s.x + ys;
            r.y   = s.y - xs;
            r.acc = s.acc + ATAN_TAB[i];
        end
        else
        begin
            r.x   = s.x - ys;
            r.y   = s.y + xs;
            r.acc = s.acc - ATAN_TAB[i];
        end
        return r;
    endfunction

    // One result bit of the restoring square root, radicand digit j
    function automatic sq_t sqrt_step(sq_t s, int j);
        sq_t         r;
        logic [32:0] rw;
        logic [32:0] tr;
        r  = s;
        rw = {s.rem, s.rad[2*j +: 2]};
        tr = {2'b00, s.root, 2'b01};
        if (rw >= tr)
        begin
            r.rem  = 31'(rw - tr);
            r.root = {s.root[27:0], 1'b1};
        end
        else
        begin
            r.rem  = rw[30:0];
            r.root = {s.root[27:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== hdl/quat_to_euler_zxy.sv =====
// Quaternion (Q1.14) to z-x-y Euler angles in 1/128 degree.
// A pushed item passes front stages, queue, entry register, sqrt/CORDIC pipes, result register.
// Throughput: one item per cycle unless stalled; set by the fully pipelined sqrt and CORDIC stages.
// Back pressure stalls the back end as a whole; the 4-entry queue lets the front keep taking items.
// Reset (rst_n, async, active low) empties all stages and the queue; no clearing pass.
// Depends on qte_pkg, qte_front, qte_queue, qte_back.
module quat_to_euler_zxy
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic signed [15:0] roll_angle,
    output logic               pitch_clamped
);

    logic q_push, q_full, q_pop, q_empty;
    mid_t q_wr, q_rd;

    qte_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .q_push (q_push),
        .q_item (q_wr),
        .q_full (q_full)
    );

    qte_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .rd_item (q_rd),
        .empty   (q_empty)
    );

    qte_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (q_rd),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .pitch_angle   (pitch_angle),
        .yaw_angle     (yaw_angle),
        .roll_angle    (roll_angle),
        .pitch_clamped (pitch_clamped)
    );

endmodule

// ===== hdl/qte_front.sv =====
// Front end: accepts quaternions, forms the Q28 sine/cosine terms and the pitch radicand.
// Four stall-together stages feeding the mid queue. Depends on qte_pkg.
module qte_front
    import qte_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  quat_t quat_w,
    input  quat_t quat_x,
    input  quat_t quat_y,
    input  quat_t quat_z,
    output logic  q_push,
    output mid_t  q_item,
    input  logic  q_full
);

    typedef struct packed {
        prod_t wz, xy, xx, zz, wy, xz, yy, wx, zy;
    } prods_t;

    typedef struct packed {
        wide_t sr, cr, sy, cy, sp;
    } terms_t;

    typedef struct packed {
        terms_t     t;
        logic       clamp;
        logic [55:0] sq;
    } sqr_t;

    logic   en;
    logic   acc_in;
    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    prods_t p1_reg, p1_next;
    terms_t t2_reg, t2_next;
    sqr_t   s3_reg, s3_next;
    mid_t   s4_reg, s4_next;

    logic signed [32:0] sum_r, sum_y, sqs_r, sqs_y, dif_p;
    wide_t              cr_sub, cy_sub, sp_abs;
    logic [27:0]        mag;

    // whole front stalls only when the last stage cannot drain
    assign en     = !(v4_reg && q_full);
    assign full   = !en;
    assign acc_in = push && en;
    assign q_push = v4_reg && !q_full;
    assign q_item = s4_reg;

    // stage 1: products
    always_comb
    begin
        p1_next.wz = quat_w * quat_z;
        p1_next.xy = quat_x * quat_y;
        p1_next.xx = quat_x * quat_x;
        p1_next.zz = quat_z * quat_z;
        p1_next.wy = quat_w * quat_y;
        p1_next.xz = quat_x * quat_z;
        p1_next.yy = quat_y * quat_y;
        p1_next.wx = quat_w * quat_x;
        p1_next.zy = quat_z * quat_y;
    end

    // stage 2: sums, doubled
    always_comb
    begin
        sum_r = 33'(p1_reg.wz) + 33'(p1_reg.xy);
        sum_y = 33'(p1_reg.wy) + 33'(p1_reg.xz);
        sqs_r = 33'(p1_reg.xx) + 33'(p1_reg.zz);
        sqs_y = 33'(p1_reg.yy) + 33'(p1_reg.xx);
        dif_p = 33'(p1_reg.wx) - 33'(p1_reg.zy);
        cr_sub = {sqs_r, 1'b0};
        cy_sub = {sqs_y, 1'b0};
        t2_next.sr = {sum_r, 1'b0};
        t2_next.sy = {sum_y, 1'b0};
        t2_next.sp = {dif_p, 1'b0};
        t2_next.cr = ONE_Q28 - cr_sub;
        t2_next.cy = ONE_Q28 - cy_sub;
    end

    // stage 3: clamp detect and sp squared
    always_comb
    begin
        sp_abs        = t2_reg.sp[33] ? -t2_reg.sp : t2_reg.sp;
        s3_next.t     = t2_reg;
        s3_next.clamp = |sp_abs[33:28];
        mag           = s3_next.clamp ? '0 : sp_abs[27:0];
        s3_next.sq    = mag * mag;
    end

    // stage 4: radicand 2^56 - sp^2
    always_comb
    begin
        s4_next.sr    = s3_reg.t.sr;
        s4_next.cr    = s3_reg.t.cr;
        s4_next.sy    = s3_reg.t.sy;
        s4_next.cy    = s3_reg.t.cy;
        s4_next.sp    = s3_reg.t.sp;
        s4_next.clamp = s3_reg.clamp;
        s4_next.rad   = RAD_ONE - {1'b0, s3_reg.sq};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= acc_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= p1_next;
            t2_reg <= t2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

endmodule

// ===== hdl/qte_queue.sv =====
// Short request queue between the front end and the back end.
// Register file of Q_DEPTH entries. Depends on qte_pkg.
module qte_queue
    import qte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  mid_t wr_item,
    output logic full,
    input  logic pop,
    output mid_t rd_item,
    output logic empty
);

    mid_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue overfilled");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");

endmodule

// ===== hdl/qte_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage, SQRT_LAT stages.
// Gives floor(sqrt(rad)). Depends on qte_pkg.
module qte_sqrt
    import qte_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  rad_t  rad,
    output root_t root
);

    sq_t st_reg [SQRT_LAT];
    sq_t st_init;

    assign st_init.rad  = {1'b0, rad};
    assign st_init.rem  = '0;
    assign st_init.root = '0;
    assign root         = st_reg[SQRT_LAT-1].root;

    // first digit from the radicand
    always_ff @(posedge clk)
    begin
        if (en)
            st_reg[0] <= sqrt_step(st_init, SQRT_LAT - 1);
    end

    // remaining digits
    for (genvar s = 1; s < SQRT_LAT; s++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[s] <= sqrt_step(st_reg[s-1], SQRT_LAT - 1 - s);
        end
    end

endmodule

// ===== hdl/qte_cordic.sv =====
// Pipelined atan2 in vectoring mode: fold, magnitude, normalize, 20 rotations, round.
// CORDIC_LAT stages, result in 1/128 degree, unsaturated. Depends on qte_pkg.
module qte_cordic
    import qte_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  wide_t  y_in,
    input  wide_t  x_in,
    output angle_t angle
);

    localparam int P_LAST = NORM_STAGES + CORDIC_STEPS;

    typedef struct packed {
        logic              zero;
        acc_t              acc;
        logic signed [34:0] x;
        logic signed [34:0] y;
    } fold_t;

    fold_t              f_reg, f_next;
    cst_t               p_reg [P_LAST+1];
    cst_t               m_next;
    angle_t             angle_reg;
    logic signed [34:0] x35, y35, ay, mx;
    acc_t               rnd;

    assign angle = angle_reg;

    // fold into right half plane
    always_comb
    begin
        x35         = 35'(x_in);
        y35         = 35'(y_in);
        f_next.zero = (x_in == '0) && (y_in == '0);
        f_next.acc  = '0;
        f_next.x    = x35;
        f_next.y    = y35;
        if (x35[34])
        begin
            f_next.acc = y35[34] ? -DEG180_FINE : DEG180_FINE;
            f_next.x   = -x35;
            f_next.y   = -y35;
        end
    end

    // larger magnitude
    always_comb
    begin
        ay          = f_reg.y[34] ? -f_reg.y : f_reg.y;
        mx          = (f_reg.x > ay) ? f_reg.x : ay;
        m_next.zero = f_reg.zero;
        m_next.acc  = f_reg.acc;
        m_next.m    = MAG_W'(mx);
        m_next.x    = 44'(f_reg.x);
        m_next.y    = 44'(f_reg.y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg    <= f_next;
            p_reg[0] <= m_next;
        end
    end

    // normalize shifter, one power of two per stage
    for (genvar g = 0; g < NORM_STAGES; g++)
    begin : g_norm
        always_ff @(posedge clk)
        begin
            if (en)
                p_reg[g+1] <= norm_step(p_reg[g], NORM_SH[g]);
        end
    end

    // rotations
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (en)
                p_reg[NORM_STAGES+1+i] <= cordic_step(p_reg[NORM_STAGES+i], i);
        end
    end

    // round to 1/128 degree
    assign rnd = p_reg[P_LAST].acc + ACC_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= p_reg[P_LAST].zero ? '0 : rnd[26:9];
    end

endmodule

// ===== hdl/qte_back.sv =====
// Back end: square root for the pitch cosine, three CORDIC pipes, result register.
// All stages advance together whenever the result register can take a new value.
// Depends on qte_pkg, qte_sqrt, qte_cordic.
module qte_back
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  mid_t               q_item,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic signed [15:0] roll_angle,
    output logic               pitch_clamped
);

    typedef struct packed {
        angle_t roll;
        angle_t yaw;
    } ry_t;

    logic               en;
    logic               in_v_reg;
    mid_t               in_reg;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic [1:0]         fl_reg [TOTAL_LAT];
    wide_t              sp_reg [SQRT_LAT];
    ry_t                ry_reg [SQRT_LAT];
    root_t              c_root;
    angle_t             roll_raw, yaw_raw, pitch_raw;
    angle_t             roll_s, yaw_s, pitch_s;
    wide_t              c_wide;
    logic               out_v_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] yaw_reg, roll_reg;
    logic               clamp_reg;
    logic               fl_clamp, fl_pos;

    function automatic angle_t sat_angle(angle_t a, angle_t lim);
        if (a > lim)
            return lim;
        if (a < -lim)
            return -lim;
        return a;
    endfunction

    assign en    = !out_v_reg || pop;
    assign q_pop = en && !q_empty;
    assign empty = !out_v_reg;

    // entry register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (en)
            in_v_reg <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            in_reg <= q_item;
    end

    // pitch cosine and roll/yaw angles in parallel
    qte_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (in_reg.rad),
        .root (c_root)
    );

    qte_cordic u_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (in_reg.sr),
        .x_in  (in_reg.cr),
        .angle (roll_raw)
    );

    qte_cordic u_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (in_reg.sy),
        .x_in  (in_reg.cy),
        .angle (yaw_raw)
    );

    assign c_wide = {5'b0, c_root};

    qte_cordic u_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (sp_reg[SQRT_LAT-1]),
        .x_in  (c_wide),
        .angle (pitch_raw)
    );

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], in_v_reg};
    end

    // side-band delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_reg[0] <= {in_reg.clamp, !in_reg.sp[33]};
            for (int k = 1; k < TOTAL_LAT; k++)
                fl_reg[k] <= fl_reg[k-1];
            sp_reg[0] <= in_reg.sp;
            for (int k = 1; k < SQRT_LAT; k++)
                sp_reg[k] <= sp_reg[k-1];
            ry_reg[0] <= '{roll: roll_raw, yaw: yaw_raw};
            for (int k = 1; k < SQRT_LAT; k++)
                ry_reg[k] <= ry_reg[k-1];
        end
    end

    // final saturation and pitch clamp
    always_comb
    begin
        fl_clamp = fl_reg[TOTAL_LAT-1][1];
        fl_pos   = fl_reg[TOTAL_LAT-1][0];
        roll_s   = sat_angle(ry_reg[SQRT_LAT-1].roll, DEG180_OUT);
        yaw_s    = sat_angle(ry_reg[SQRT_LAT-1].yaw, DEG180_OUT);
        if (fl_clamp)
            pitch_s = fl_pos ? DEG90_OUT : -DEG90_OUT;
        else
            pitch_s = sat_angle(pitch_raw, DEG90_OUT);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= vld_reg[TOTAL_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= 15'(pitch_s);
            yaw_reg   <= 16'(yaw_s);
            roll_reg  <= 16'(roll_s);
            clamp_reg <= fl_clamp;
        end
    end

    assign pitch_angle   = pitch_reg;
    assign yaw_angle     = yaw_reg;
    assign roll_angle    = roll_reg;
    assign pitch_clamped = clamp_reg;

    a_clamp_ninety: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && clamp_reg) |-> (pitch_reg == 15'sd11520 || pitch_reg == -15'sd11520))
        else $error("clamped pitch not at 90 degrees");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (roll_reg <= 16'sd23040 && roll_reg >= -16'sd23040))
        else $error("roll out of range");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !pop) |=> (out_v_reg && $stable(yaw_reg)))
        else $error("result register overwritten while held");

endmodule
